### hdl/bsc_pkg.sv
// Shared types, symmetry tables and permutation helpers for the board canonicalizer.
package bsc_pkg;

  localparam int unsigned CELL_BITS = 4;
  localparam int unsigned SIDE      = 4;
  localparam int unsigned BOARD_W   = CELL_BITS * SIDE * SIDE;
  localparam int unsigned NUM_IMG   = 7;

  typedef logic [BOARD_W-1:0] board_t;

  typedef enum logic [2:0] {
    MODE_IDENTITY = 3'd0,
    MODE_FULL     = 3'd1,
    MODE_DIAG     = 3'd2,
    MODE_HORIZ    = 3'd3,
    MODE_MIN24    = 3'd4,
    MODE_MIN33    = 3'd5,
    MODE_MIN34    = 3'd6
  } mode_t;

  typedef enum logic [4:0] {
    SYM_ID, SYM_LR, SYM_UD, SYM_TMAIN, SYM_TANTI, SYM_R180, SYM_RLEFT, SYM_RRIGHT,
    SYM_C33, SYM_R33, SYM_T33, SYM_A33, SYM_H33, SYM_RR33, SYM_RL33,
    SYM_UD34, SYM_H34
  } sym_t;

  typedef sym_t sym_set_t [0:NUM_IMG-1];

  // Short sets are padded with identity, which never lowers the minimum
  localparam sym_set_t SET_NONE  = '{SYM_ID, SYM_ID, SYM_ID, SYM_ID, SYM_ID, SYM_ID, SYM_ID};
  localparam sym_set_t SET_FULL  = '{SYM_LR, SYM_UD, SYM_TMAIN, SYM_TANTI,
                                     SYM_R180, SYM_RLEFT, SYM_RRIGHT};
  localparam sym_set_t SET_DIAG  = '{SYM_TMAIN, SYM_ID, SYM_ID, SYM_ID, SYM_ID, SYM_ID, SYM_ID};
  localparam sym_set_t SET_HORIZ = '{SYM_LR, SYM_ID, SYM_ID, SYM_ID, SYM_ID, SYM_ID, SYM_ID};
  localparam sym_set_t SET_24    = '{SYM_LR, SYM_UD, SYM_R180, SYM_ID, SYM_ID, SYM_ID, SYM_ID};
  localparam sym_set_t SET_33    = '{SYM_C33, SYM_R33, SYM_T33, SYM_A33,
                                     SYM_H33, SYM_RR33, SYM_RL33};
  localparam sym_set_t SET_34    = '{SYM_LR, SYM_UD34, SYM_H34, SYM_ID, SYM_ID, SYM_ID, SYM_ID};

  function automatic sym_t sym_select(logic [2:0] mode, logic [2:0] idx);
    sym_t sym;
    sym = SYM_ID;
    unique case (mode)
      MODE_FULL:  sym = SET_FULL[idx];
      MODE_DIAG:  sym = SET_DIAG[idx];
      MODE_HORIZ: sym = SET_HORIZ[idx];
      MODE_MIN24: sym = SET_24[idx];
      MODE_MIN33: sym = SET_33[idx];
      MODE_MIN34: sym = SET_34[idx];
      default:    sym = SET_NONE[idx];
    endcase
    return sym;
  endfunction

  // Pure wiring: destination (r,c) takes the cell named by the symmetry
  function automatic board_t sym_image(board_t board, sym_t sym);
    board_t     img;
    logic [1:0] rr;
    logic [1:0] cc;
    logic [1:0] sr;
    logic [1:0] sc;
    logic       inner;
    logic [3:0] dst;
    logic [3:0] src;
    img = '0;
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        rr    = 2'(r);
        cc    = 2'(c);
        sr    = rr;
        sc    = cc;
        inner = (rr != 2'd3) && (cc != 2'd3);
        case (sym)
          SYM_LR:     begin sr = rr;        sc = 2'd3 - cc; end
          SYM_UD:     begin sr = 2'd3 - rr; sc = cc;        end
          SYM_TMAIN:  begin sr = cc;        sc = rr;        end
          SYM_TANTI:  begin sr = 2'd3 - cc; sc = 2'd3 - rr; end
          SYM_R180:   begin sr = 2'd3 - rr; sc = 2'd3 - cc; end
          SYM_RLEFT:  begin sr = cc;        sc = 2'd3 - rr; end
          SYM_RRIGHT: begin sr = 2'd3 - cc; sc = rr;        end
          SYM_C33:  if (inner) begin sr = rr;        sc = 2'd2 - cc; end
          SYM_R33:  if (inner) begin sr = 2'd2 - rr; sc = cc;        end
          SYM_T33:  if (inner) begin sr = cc;        sc = rr;        end
          SYM_A33:  if (inner) begin sr = 2'd2 - cc; sc = 2'd2 - rr; end
          SYM_H33:  if (inner) begin sr = 2'd2 - rr; sc = 2'd2 - cc; end
          SYM_RR33: if (inner) begin sr = 2'd2 - cc; sc = rr;        end
          SYM_RL33: if (inner) begin sr = cc;        sc = 2'd2 - rr; end
          SYM_UD34: if (rr != 2'd3) begin sr = 2'd2 - rr; end
          SYM_H34: begin
            sr = (rr != 2'd3) ? 2'd2 - rr : rr;
            sc = 2'd3 - cc;
          end
          default: begin sr = rr; sc = cc; end
        endcase
        dst = {rr, cc};
        src = {sr, sc};
        img[{dst, 2'b00} +: CELL_BITS] = board[{src, 2'b00} +: CELL_BITS];
      end
    end
    return img;
  endfunction

  function automatic board_t board_min(board_t a, board_t b);
    return (b < a) ? b : a;
  endfunction

endpackage

### hdl/board_symmetry_canonicalizer.sv
// Board symmetry canonicalizer: image generation and a pipelined minimum tree.
// Stages: the image stage s1, then three compare stages s2, s3, s4 of a registered
//   8-to-1 minimum tree (four, two and one 64-bit compares); out_valid is the s4 valid bit.
// Throughput: one board per cycle while out_ready does not stall the output; each
//   stage advances on its own when the next stage is empty or moving, so bubbles
//   are squeezed out under output stall.
// Reset (rst_n low, synchronous): all stage valid bits clear, mode returns to identity.
module board_symmetry_canonicalizer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bsc_pkg::BOARD_W-1:0] in_board,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bsc_pkg::BOARD_W-1:0] out_canonical_board
);

  logic [2:0] mode_r;

  logic            v1_r, v2_r, v3_r, v4_r;
  logic            rdy1, rdy2, rdy3, rdy4;
  bsc_pkg::board_t s1_r   [0:7];
  bsc_pkg::board_t s1_nxt [0:7];
  bsc_pkg::board_t s2_r   [0:3];
  bsc_pkg::board_t s3_r   [0:1];
  bsc_pkg::board_t s4_r;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    s1_nxt[0] = in_board;
    for (int i = 0; i < bsc_pkg::NUM_IMG; i++) begin
      s1_nxt[i+1] = bsc_pkg::sym_image(in_board, bsc_pkg::sym_select(mode_r, 3'(i)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= bsc_pkg::MODE_IDENTITY;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
    end
  end

  // Payload stages, no reset
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_r <= s1_nxt;
    end
    if (rdy2 && v1_r) begin
      for (int i = 0; i < 4; i++) begin
        s2_r[i] <= bsc_pkg::board_min(s1_r[2*i], s1_r[2*i+1]);
      end
    end
    if (rdy3 && v2_r) begin
      s3_r[0] <= bsc_pkg::board_min(s2_r[0], s2_r[1]);
      s3_r[1] <= bsc_pkg::board_min(s2_r[2], s2_r[3]);
    end
    if (rdy4 && v3_r) begin
      s4_r <= bsc_pkg::board_min(s3_r[0], s3_r[1]);
    end
  end

  assign out_valid           = v4_r;
  assign out_canonical_board = s4_r;

  a_final_min: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && rdy4) |=> (s4_r <= $past(s3_r[0])) && (s4_r <= $past(s3_r[1])))
    else $error("final stage is not the minimum of its pair");

  a_stage2_min: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && rdy2) |=> (s2_r[0] <= $past(s1_r[0])) && (s2_r[0] <= $past(s1_r[1])))
    else $error("first compare stage is not a minimum");

  a_identity_imgs: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && mode_r == bsc_pkg::MODE_IDENTITY) |=>
      (s1_r[1] == s1_r[0]) && (s1_r[7] == s1_r[0]))
    else $error("identity mode produced a differing image");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v1_r && v2_r && v3_r && v4_r && !out_ready))
    else $error("input stalled while the pipeline has a bubble");

  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && !out_ready) |=> v4_r && $stable(s4_r))
    else $error("pending result changed before transfer");

endmodule

### test/board_symmetry_canonicalizer_tb.sv
// Self-checking testbench for the board symmetry canonicalizer.
`timescale 1ns / 100ps

module board_symmetry_canonicalizer_tb;

  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 64;
  localparam int PHASE_ITEMS  = 50;

  // Unused mode code, behaves as identity
  localparam logic [2:0] MODE_SPARE = 3'd7;

  // Cell permutations used by the symmetry sets
  typedef enum int {
    XF_LR, XF_UD, XF_TR_MAIN, XF_TR_ANTI, XF_TURN180, XF_TURN_L, XF_TURN_R,
    XF_IN_LR, XF_IN_UD, XF_IN_TR, XF_IN_ANTI, XF_IN_180, XF_IN_R, XF_IN_L,
    XF_TOP3_UD, XF_TOP3_TURN
  } xform_t;

  class canon_tracker_t;
    logic [2:0]      mode;
    bsc_pkg::board_t expected_canon[$];
    int              errors;
    int              checked;

    function new();
      mode    = bsc_pkg::MODE_IDENTITY;
      errors  = 0;
      checked = 0;
    endfunction

    function void set_mode(logic [2:0] m);
      mode = m;
    endfunction

    function int pending();
      return expected_canon.size();
    endfunction

    // Destination cell (r,c) takes source cell (sr,sc)
    function bsc_pkg::board_t remap(bsc_pkg::board_t b, xform_t xf);
      bsc_pkg::board_t img;
      int              sr;
      int              sc;
      bit              in3;
      img = '0;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          sr  = r;
          sc  = c;
          in3 = (r < 3) && (c < 3);
          case (xf)
            XF_LR:        sc = 3 - c;
            XF_UD:        sr = 3 - r;
            XF_TR_MAIN:   begin sr = c;     sc = r;     end
            XF_TR_ANTI:   begin sr = 3 - c; sc = 3 - r; end
            XF_TURN180:   begin sr = 3 - r; sc = 3 - c; end
            XF_TURN_L:    begin sr = c;     sc = 3 - r; end
            XF_TURN_R:    begin sr = 3 - c; sc = r;     end
            XF_IN_LR:     if (in3) sc = 2 - c;
            XF_IN_UD:     if (in3) sr = 2 - r;
            XF_IN_TR:     if (in3) begin sr = c;     sc = r;     end
            XF_IN_ANTI:   if (in3) begin sr = 2 - c; sc = 2 - r; end
            XF_IN_180:    if (in3) begin sr = 2 - r; sc = 2 - c; end
            XF_IN_R:      if (in3) begin sr = 2 - c; sc = r;     end
            XF_IN_L:      if (in3) begin sr = c;     sc = 2 - r; end
            XF_TOP3_UD:   if (r < 3) sr = 2 - r;
            XF_TOP3_TURN: begin
              sr = (r < 3) ? 2 - r : r;
              sc = 3 - c;
            end
            default: ;
          endcase
          img[4*(4*r+c) +: 4] = b[4*(4*sr+sc) +: 4];
        end
      end
      return img;
    endfunction

    function bsc_pkg::board_t canonical_of(bsc_pkg::board_t b);
      xform_t          xfs[$];
      bsc_pkg::board_t best;
      bsc_pkg::board_t img;
      case (mode)
        bsc_pkg::MODE_FULL:  xfs = '{XF_LR, XF_UD, XF_TR_MAIN, XF_TR_ANTI,
                                     XF_TURN180, XF_TURN_L, XF_TURN_R};
        bsc_pkg::MODE_DIAG:  xfs = '{XF_TR_MAIN};
        bsc_pkg::MODE_HORIZ: xfs = '{XF_LR};
        bsc_pkg::MODE_MIN24: xfs = '{XF_LR, XF_UD, XF_TURN180};
        bsc_pkg::MODE_MIN33: xfs = '{XF_IN_LR, XF_IN_UD, XF_IN_TR, XF_IN_ANTI,
                                     XF_IN_180, XF_IN_R, XF_IN_L};
        bsc_pkg::MODE_MIN34: xfs = '{XF_LR, XF_TOP3_UD, XF_TOP3_TURN};
        default:             xfs = {};  // identity and the unused code
      endcase
      best = b;
      foreach (xfs[i]) begin
        img = remap(b, xfs[i]);
        if (img < best) best = img;
      end
      return best;
    endfunction

    function void note_board(bsc_pkg::board_t b);
      expected_canon = {expected_canon, canonical_of(b)};
    endfunction

    task report(string what, bsc_pkg::board_t got, bsc_pkg::board_t want);
      $display("[%0t] mismatch (%s): got %h want %h mode %0d", $time, what, got, want, mode);
      errors++;
    endtask

    task check_canon(bsc_pkg::board_t got);
      bsc_pkg::board_t want;
      if (expected_canon.size() == 0) begin
        report("result with nothing pending", got, '0);
      end else begin
        want = expected_canon.pop_front();
        checked++;
        if (got !== want) report("canonical_board", got, want);
      end
    endtask
  endclass

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            cfg_we    = 1'b0;
  logic [2:0]      cfg_wdata = '0;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  bsc_pkg::board_t in_board  = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  bsc_pkg::board_t out_canonical_board;

  canon_tracker_t tracker = new();

  int rx_style   = 0;
  bit hold_req   = 1'b0;
  int holds_done = 0;
  int mode_writes = 0;
  int boards_sent = 0;

  board_symmetry_canonicalizer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_board            (in_board),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_canonical_board (out_canonical_board)
  );

  always #2 clk = ~clk;

  initial begin
    #400000;
    $display("board_symmetry_canonicalizer_tb: FAIL");
    $finish;
  end

  // Receiver: checks each transfer, then picks out_ready for the next edge
  initial begin
    int hold_left;
    int phase;
    hold_left = 0;
    phase     = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) tracker.check_canon(out_canonical_board);
      phase = (phase + 1) % 5;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        holds_done++;
        out_ready <= 1'b0;
      end else begin
        case (rx_style)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= (phase >= 2);
          default: out_ready <= ($urandom_range(0, 9) < 4);
        endcase
      end
    end
  end

  function automatic bsc_pkg::board_t make_board();
    bsc_pkg::board_t b;
    int              k;
    k = $urandom_range(0, 3);
    b = '0;
    case (k)
      0: b = {$urandom, $urandom};
      1: for (int i = 0; i < 16; i++) b[4*i +: 4] = 4'($urandom_range(0, 2));
      2: repeat ($urandom_range(1, 3)) b[4*$urandom_range(0, 15) +: 4] = 4'($urandom_range(1, 15));
      default: begin
        // all cells equal but possibly one: ties run deep into the compare
        b = {16{4'($urandom_range(0, 15))}};
        b[4*$urandom_range(0, 15) +: 4] = 4'($urandom_range(0, 15));
      end
    endcase
    return b;
  endfunction

  task automatic push_board(bsc_pkg::board_t b);
    in_valid <= 1'b1;
    in_board <= b;
    do @(posedge clk); while (!in_ready);
    tracker.note_board(b);
    boards_sent++;
  endtask

  task automatic write_mode(logic [2:0] m);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_mode(m);
    mode_writes++;
  endtask

  task automatic run_phase(logic [2:0] m, int style, bit gappy, bit hold);
    int burst;
    write_mode(m);
    rx_style = style;
    if (hold) hold_req = 1'b1;
    burst = $urandom_range(1, 10);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      push_board(make_board());
      burst--;
      if (gappy && burst == 0 && i != PHASE_ITEMS - 1) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst = $urandom_range(1, 10);
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    logic [2:0]      phase_modes [11];
    bsc_pkg::board_t probes [3];
    phase_modes = '{bsc_pkg::MODE_FULL, bsc_pkg::MODE_IDENTITY, bsc_pkg::MODE_DIAG,
                    bsc_pkg::MODE_HORIZ, bsc_pkg::MODE_MIN24, bsc_pkg::MODE_MIN33,
                    bsc_pkg::MODE_MIN34, MODE_SPARE, bsc_pkg::MODE_FULL,
                    bsc_pkg::MODE_MIN33, bsc_pkg::MODE_MIN34};
    probes = '{64'hFEDC_BA98_7654_3210, 64'h1000_0000_0000_F002, 64'h0000_0F00_00A0_0001};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    rx_style = 1;

    // Directed: field extremes in the reset mode, then a few probes per mode
    push_board('0);
    push_board('1);
    push_board(64'h0123_4567_89AB_CDEF);
    in_valid <= 1'b0;
    for (int m = 1; m < 8; m++) begin
      write_mode(3'(m));
      push_board(probes[0]);
      push_board(probes[m % 3 == 0 ? 1 : 2]);
      in_valid <= 1'b0;
    end

    // Random phases; the receiver holds off long in two of them
    for (int p = 0; p < 11; p++)
      run_phase(phase_modes[p], p % 4, p % 3 != 0, p == 2 || p == 8);

    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d of %0d boards across %0d mode writes (codes 0-7)",
             tracker.checked, boards_sent, mode_writes);
    $display("receiver held off %0d times for %0d cycles each", holds_done, HOLD_CYCLES);
    if (tracker.errors == 0) begin
      $display("board_symmetry_canonicalizer_tb: PASS");
    end else begin
      $display("board_symmetry_canonicalizer_tb: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/bsc_pkg.sv
hdl/board_symmetry_canonicalizer.sv
test/board_symmetry_canonicalizer_tb.sv
